// ===== rtl/p2c_pkg.sv =====
// Shared constants, types and the arctangent table of the polar to Cartesian converter.
package p2c_pkg;

  localparam int unsigned RangeW      = 16;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned AngleW      = 32;
  localparam int unsigned CoordW      = 17;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CfgIdxW     = 2;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned FracBits    = 30;
  // Datapath width of x and y: |v| stays below 65535 * 2^30 < 2^46.
  localparam int unsigned VecW        = 48;
  // Residual angle width: a folded angle plus the first arctangent fits with margin.
  localparam int unsigned ZW          = 34;

  localparam int unsigned PipeDepth   = CordicSteps + 3;

  // Inverse CORDIC gain for thirty rotations, thirty fraction bits.
  localparam logic signed [31:0] GainInvQ30 = 32'sd652032874;
  localparam int CoordLimit = 65535;

  localparam logic [RangeW-1:0] MaxRangeReset = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartAngle = 2'd0,
    CfgAngleStep  = 2'd1,
    CfgMaxRange   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
  } cordic_vec_t;

  // Arctangent of 2^-step in binary angle units, 2^32 per turn.
  function automatic logic [AngleW-1:0] atan_turns(input int unsigned step);
    logic [AngleW-1:0] a;
    case (step)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      24:      a = 32'h00000029;
      25:      a = 32'h00000014;
      26:      a = 32'h0000000A;
      27:      a = 32'h00000005;
      28:      a = 32'h00000003;
      29:      a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/p2c_in_if.sv =====
// Input channel interface: one lidar sample per beat.
interface p2c_in_if;
  import p2c_pkg::*;

  logic              valid;
  logic              ready;
  logic [RangeW-1:0] range_mm;
  logic              range_valid;
  logic [IdxW-1:0]   sample_index;

  modport source (output valid, output range_mm, output range_valid,
                  output sample_index, input ready);
  modport sink   (input valid, input range_mm, input range_valid,
                  input sample_index, output ready);
endinterface

// ===== rtl/p2c_out_if.sv =====
// Result channel interface: one Cartesian point per beat.
interface p2c_out_if;
  import p2c_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/p2c_front.sv =====
// Front end: beam angle, range substitution, quadrant fold and gain-scaled start vector.
module p2c_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [p2c_pkg::RangeW-1:0]        range_mm,
  input  logic                              range_valid,
  input  logic [p2c_pkg::IdxW-1:0]          sample_index,
  input  logic [p2c_pkg::AngleW-1:0]        start_angle,
  input  logic [p2c_pkg::AngleW-1:0]        angle_step,
  input  logic [p2c_pkg::RangeW-1:0]        max_range,
  output logic                              out_valid,
  input  logic                              out_ready,
  output p2c_pkg::cordic_vec_t              out_vec
);
  import p2c_pkg::*;

  logic                    a_valid_r;
  logic [RangeW-1:0]       a_range_r;
  logic [AngleW-1:0]       a_ang_r;
  logic                    a_ready;
  logic [AngleW-1:0]       ang_nxt;

  logic                    b_valid_r;
  cordic_vec_t             b_vec_r;
  logic                    b_ready;
  logic                    fold;
  logic signed [31:0]      gain;
  logic signed [RangeW:0]  range_s;
  logic signed [VecW:0]    prod;
  logic [AngleW-1:0]       ang_f;
  cordic_vec_t             b_vec_nxt;

  // The angle wraps modulo 2^32, so the sample index needs no reduction.
  assign ang_nxt  = start_angle + AngleW'(angle_step * AngleW'(sample_index));
  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_range_r <= range_valid ? range_mm : max_range;
      a_ang_r   <= ang_nxt;
    end
  end

  // Angles outside the right half plane turn by half a turn; the start
  // vector is negated to compensate, folded into the sign of the gain.
  assign fold    = a_ang_r[AngleW-1] ^ a_ang_r[AngleW-2];
  assign gain    = fold ? -GainInvQ30 : GainInvQ30;
  assign range_s = $signed({1'b0, a_range_r});
  assign prod    = range_s * gain;
  assign ang_f   = a_ang_r ^ {fold, {(AngleW-1){1'b0}}};

  always_comb begin
    b_vec_nxt.x = $signed(prod[VecW-1:0]);
    b_vec_nxt.y = '0;
    b_vec_nxt.z = $signed({{(ZW-AngleW){ang_f[AngleW-1]}}, ang_f});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
    if (b_ready && a_valid_r) begin
      b_vec_r <= b_vec_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_vec   = b_vec_r;

endmodule

// ===== rtl/p2c_cordic_stage.sv =====
// One registered CORDIC rotation step with a fixed shift and arctangent.
module p2c_cordic_stage #(
  parameter int unsigned Step = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  p2c_pkg::cordic_vec_t in_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output p2c_pkg::cordic_vec_t out_vec
);
  import p2c_pkg::*;

  localparam logic [AngleW-1:0] Atan = atan_turns(Step);

  logic                   valid_r;
  cordic_vec_t            vec_r;
  cordic_vec_t            vec_nxt;
  logic signed [VecW-1:0] dx;
  logic signed [VecW-1:0] dy;
  logic signed [ZW-1:0]   da;

  assign dx = in_vec.y >>> Step;
  assign dy = in_vec.x >>> Step;
  assign da = $signed({{(ZW-AngleW){1'b0}}, Atan});

  always_comb begin
    if (!in_vec.z[ZW-1]) begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - da;
    end else begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + da;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// ===== rtl/p2c_round.sv =====
// Output stage: round to the nearest millimetre, clamp and hold the point.
module p2c_round (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  p2c_pkg::cordic_vec_t              in_vec,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [p2c_pkg::CoordW-1:0] point_x,
  output logic signed [p2c_pkg::CoordW-1:0] point_y
);
  import p2c_pkg::*;

  localparam logic signed [VecW-1:0] Half   = VecW'(64'sd1 <<< (FracBits - 1));
  localparam logic signed [VecW-1:0] LimPos = VecW'(CoordLimit);
  localparam logic signed [VecW-1:0] LimNeg = -VecW'(CoordLimit);

  logic                     valid_r;
  logic signed [CoordW-1:0] x_r;
  logic signed [CoordW-1:0] y_r;

  // Ties round toward plus infinity.
  function automatic logic signed [CoordW-1:0] finish(input logic signed [VecW-1:0] v);
    logic signed [VecW-1:0] r;
    logic signed [CoordW-1:0] c;
    r = (v + Half) >>> FracBits;
    if (r > LimPos) begin
      c = CoordW'(CoordLimit);
    end else if (r < LimNeg) begin
      c = -CoordW'(CoordLimit);
    end else begin
      c = r[CoordW-1:0];
    end
    return c;
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      x_r <= finish(in_vec.x);
      y_r <= finish(in_vec.y);
    end
  end

  assign out_valid = valid_r;
  assign point_x   = x_r;
  assign point_y   = y_r;

endmodule

// ===== rtl/lidar_scan_polar_to_cartesian_core.sv =====
// Top level of the lidar sample to Cartesian point converter.
//
// Each input beat carries one beam: range_mm, range_valid and sample_index.
// The beam angle is start_angle + angle_step * sample_index in binary angle
// units (2^32 per turn, wrapping). A beam marked invalid uses max_range.
// Each input beat produces exactly one output beat with point_x and point_y,
// the rounded and clamped Cartesian coordinates in millimetres.
//
// From input beat to output valid a beat passes these stages: one forms the
// angle, one multiplies the range by the inverse CORDIC gain, thirty stages
// each perform one CORDIC rotation, and one stage rounds and clamps.
// Throughput is one beat per cycle; every stage holds its own valid bit.
// When the receiver stalls, beats pile up into empty stages and in_s.ready
// only drops once all 33 stages hold data; nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the registers
// (start_angle 0, angle_step 0, max_range 65535). Write registers through
// the cfg_ port only while no beat is in flight.
module lidar_scan_polar_to_cartesian_core (
  input  logic                         clk,
  input  logic                         rst_n,
  p2c_in_if.sink                       in_s,
  p2c_out_if.source                    out_s,
  input  logic                         cfg_we,
  input  logic [p2c_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [p2c_pkg::CfgDataW-1:0] cfg_wdata
);
  import p2c_pkg::*;

  localparam int unsigned OccW = $clog2(PipeDepth + 1);

  logic [AngleW-1:0] start_angle_r;
  logic [AngleW-1:0] angle_step_r;
  logic [RangeW-1:0] max_range_r;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      max_range_r   <= MaxRangeReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CfgStartAngle: start_angle_r <= cfg_wdata[AngleW-1:0];
        CfgAngleStep:  angle_step_r  <= cfg_wdata[AngleW-1:0];
        CfgMaxRange:   max_range_r   <= cfg_wdata[RangeW-1:0];
        default: ;
      endcase
    end
  end

  // Stage chain: index 0 is the front end output, index k+1 the output of
  // rotation k, and the last entry feeds the rounding stage.
  logic [CordicSteps:0] stg_valid;
  logic [CordicSteps:0] stg_ready;
  cordic_vec_t          stg_vec [CordicSteps+1];

  p2c_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_s.valid),
    .in_ready     (in_s.ready),
    .range_mm     (in_s.range_mm),
    .range_valid  (in_s.range_valid),
    .sample_index (in_s.sample_index),
    .start_angle  (start_angle_r),
    .angle_step   (angle_step_r),
    .max_range    (max_range_r),
    .out_valid    (stg_valid[0]),
    .out_ready    (stg_ready[0]),
    .out_vec      (stg_vec[0])
  );

  for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
    p2c_cordic_stage #(
      .Step (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .in_vec    (stg_vec[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .out_vec   (stg_vec[k+1])
    );
  end

  p2c_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[CordicSteps]),
    .in_ready  (stg_ready[CordicSteps]),
    .in_vec    (stg_vec[CordicSteps]),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .point_x   (out_s.point_x),
    .point_y   (out_s.point_y)
  );

  // Number of beats accepted but not yet delivered.
  logic [OccW-1:0] occ_r;
  logic [OccW-1:0] occ_nxt;
  logic            acc_in;
  logic            acc_out;

  assign acc_in  = in_s.valid && in_s.ready;
  assign acc_out = out_s.valid && out_s.ready;

  always_comb begin
    occ_nxt = occ_r;
    if (acc_in && !acc_out) begin
      occ_nxt = occ_r + OccW'(1);
    end else if (!acc_in && acc_out) begin
      occ_nxt = occ_r - OccW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // The pipeline never holds more beats than it has stages.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OccW'(PipeDepth))
    else $error("more beats in flight than pipeline stages");

  // A result only appears for a beat that was accepted earlier.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> !out_s.valid)
    else $error("output valid with no beat in flight");

  // A full pipeline must push back on the input side while the output stalls.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == OccW'(PipeDepth)) && !out_s.ready |-> !in_s.ready)
    else $error("input ready while every stage is occupied");

  // Clamping keeps both coordinates off the most negative code.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> (out_s.point_x != {1'b1, {(CoordW-1){1'b0}}}) &&
                    (out_s.point_y != {1'b1, {(CoordW-1){1'b0}}}))
    else $error("coordinate outside the clamped range");

endmodule
